### sv/lrpg_pkg.sv
// ----------------------------------------------------------------------------
// lrpg_pkg
// Shared types, codes and colour helpers for the LED ring pattern generator.
// ----------------------------------------------------------------------------
package lrpg_pkg;

  localparam int PIXELS_DEF = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAINBOW_STEP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_IV     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPINNER_IV   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREATHE_STEP = 4'd3;

  localparam logic CMD_SET    = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_SOLID   = 3'd1;
  localparam logic [2:0] MODE_RAINBOW = 3'd2;
  localparam logic [2:0] MODE_CHASE   = 3'd3;
  localparam logic [2:0] MODE_BREATHE = 3'd4;
  localparam logic [2:0] MODE_SPINNER = 3'd5;

  localparam logic [1:0] FK_FLAT    = 2'd0;
  localparam logic [1:0] FK_RAINBOW = 2'd1;
  localparam logic [1:0] FK_DOTS    = 2'd2;

  typedef struct packed {
    logic        command;
    logic [2:0]  mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic calc;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic frame_done;
    logic out_free;
  } dp_status_t;

  // full saturation and value; region found by compares against multiples of 43
  function automatic logic [23:0] hue_to_rgb(input logic [7:0] hue);
    logic [2:0]  region;
    logic [7:0]  base;
    logic [8:0]  rem9;
    logic [7:0]  rem;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    if (hue >= 8'd215) begin
      region = 3'd5; base = 8'd215;
    end else if (hue >= 8'd172) begin
      region = 3'd4; base = 8'd172;
    end else if (hue >= 8'd129) begin
      region = 3'd3; base = 8'd129;
    end else if (hue >= 8'd86) begin
      region = 3'd2; base = 8'd86;
    end else if (hue >= 8'd43) begin
      region = 3'd1; base = 8'd43;
    end else begin
      region = 3'd0; base = 8'd0;
    end
    rem9   = 9'(hue - base) * 9'd6;
    rem    = rem9[7:0];
    prod_q = 16'(rem) * 16'd255;
    prod_q = 16'(8'd255 - prod_q[15:8]) * 16'd255;
    q      = prod_q[15:8];
    prod_t = 16'(8'd255 - rem) * 16'd255;
    prod_t = 16'(8'd255 - prod_t[15:8]) * 16'd255;
    t      = prod_t[15:8];
    case (region)
      3'd0: begin r = 8'd255; g = t;      b = 8'd0;   end
      3'd1: begin r = q;      g = 8'd255; b = 8'd0;   end
      3'd2: begin r = 8'd0;   g = 8'd255; b = t;      end
      3'd3: begin r = 8'd0;   g = q;      b = 8'd255; end
      3'd4: begin r = t;      g = 8'd0;   b = 8'd255; end
      default: begin r = 8'd255; g = 8'd0; b = q; end
    endcase
    return {r, g, b};
  endfunction

  // c * l / 255 for 8-bit operands, reciprocal form
  function automatic logic [7:0] scale255(input logic [7:0] c, input logic [7:0] l);
    logic [16:0] x;
    logic [16:0] s;
    x = 17'(c) * 17'(l);
    s = x + 17'd1 + (x >> 8);
    return s[15:8];
  endfunction

endpackage

### sv/lrpg_ctrl.sv
// ----------------------------------------------------------------------------
// lrpg_ctrl
// Sequencer: accept, decide, frame set-up and per-pixel emission.
// ----------------------------------------------------------------------------
module lrpg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lrpg_pkg::dp_status_t   status,
  output lrpg_pkg::ctrl_cmd_t    cmd
);
  import lrpg_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_CALC   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.latch  = in_valid && in_ready;
  assign cmd.decide = (state_r == S_DECIDE);
  assign cmd.calc   = (state_r == S_CALC);
  assign cmd.load   = (state_r == S_EMIT) && status.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.latch) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = status.emit ? S_CALC : S_IDLE;
      end
      S_CALC: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.load && status.frame_done) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### sv/lrpg_datapath.sv
// ----------------------------------------------------------------------------
// lrpg_datapath
// Registers, animation state, frame set-up and pixel generation.
// ----------------------------------------------------------------------------
module lrpg_datapath #(
  parameter int PIXELS = lrpg_pkg::PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrpg_pkg::in_item_t                  in_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrpg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lrpg_pkg::out_item_t                 out_item,
  input  lrpg_pkg::ctrl_cmd_t                 cmd,
  output lrpg_pkg::dp_status_t                status
);
  import lrpg_pkg::*;

  localparam logic [6:0] PIX7  = 7'(PIXELS);
  localparam logic [5:0] LAST  = 6'(PIXELS - 1);
  localparam logic [5:0] HALF  = 6'(PIXELS / 2);
  localparam logic [7:0] QSTEP = 8'(256 / PIXELS);
  localparam logic [6:0] RSTEP = 7'(256 % PIXELS);

  in_item_t    item_r;

  logic [7:0]  rainbow_step_r;
  logic [15:0] chase_iv_r;
  logic [15:0] spin_iv_r;
  logic [7:0]  breathe_step_r;

  logic [2:0]  cur_mode_r,     cur_mode_nxt;
  logic [23:0] cur_colour_r,   cur_colour_nxt;
  logic [7:0]  shown_mode_r,   shown_mode_nxt;
  logic [23:0] shown_colour_r, shown_colour_nxt;
  logic [7:0]  anim_offset_r,  anim_offset_nxt;
  logic [5:0]  pos_r,          pos_nxt;
  logic [7:0]  level_r,        level_nxt;
  logic        falling_r,      falling_nxt;
  logic [31:0] last_step_r,    last_step_nxt;
  logic        redraw_r,       redraw_nxt;

  logic [1:0]  kind_r,   kind_nxt;
  logic [23:0] frame_rgb_r;
  logic        spin_r;
  logic [5:0]  pos1_r;
  logic [5:0]  pos2_r;
  logic [7:0]  hoff_r;
  logic [5:0]  cnt_r;
  logic [7:0]  hq_r;
  logic [6:0]  hr_r;

  logic        out_valid_r;
  out_item_t   out_r;

  logic        emit;
  logic [23:0] item_colour;
  logic [31:0] elapsed;
  logic [15:0] interval;
  logic [9:0]  lvl;
  logic [6:0]  pos2_sum;
  logic [5:0]  pos2;

  assign item_colour = {item_r.red, item_r.green, item_r.blue};
  assign elapsed     = item_r.now_ms - last_step_r;
  assign interval    = (cur_mode_r == MODE_CHASE) ? chase_iv_r : spin_iv_r;
  assign pos2_sum    = {1'b0, pos_r} + {1'b0, HALF};
  assign pos2        = (pos2_sum >= PIX7) ? 6'(pos2_sum - PIX7) : pos2_sum[5:0];

  always_comb begin
    cur_mode_nxt     = cur_mode_r;
    cur_colour_nxt   = cur_colour_r;
    shown_mode_nxt   = shown_mode_r;
    shown_colour_nxt = shown_colour_r;
    anim_offset_nxt  = anim_offset_r;
    pos_nxt          = pos_r;
    level_nxt        = level_r;
    falling_nxt      = falling_r;
    last_step_nxt    = last_step_r;
    redraw_nxt       = redraw_r;
    kind_nxt         = FK_FLAT;
    emit             = 1'b0;
    lvl              = '0;
    if (item_r.command == CMD_SET) begin
      if (item_r.mode != cur_mode_r || item_colour != cur_colour_r) redraw_nxt = 1'b1;
      if (item_r.mode != cur_mode_r) begin
        anim_offset_nxt = '0;
        pos_nxt         = '0;
        level_nxt       = '0;
        falling_nxt     = 1'b0;
      end
      cur_mode_nxt   = item_r.mode;
      cur_colour_nxt = item_colour;
    end else begin
      case (cur_mode_r)
        MODE_RAINBOW: begin
          emit            = 1'b1;
          kind_nxt        = FK_RAINBOW;
          anim_offset_nxt = anim_offset_r + rainbow_step_r;
          shown_mode_nxt  = {5'd0, cur_mode_r};
        end
        MODE_CHASE, MODE_SPINNER: begin
          kind_nxt       = FK_DOTS;
          shown_mode_nxt = {5'd0, cur_mode_r};
          if (elapsed >= {16'd0, interval}) begin
            emit            = 1'b1;
            anim_offset_nxt = anim_offset_r + 8'd1;
            last_step_nxt   = item_r.now_ms;
            // position tracks anim_offset mod PIXELS, including the 8-bit wrap
            if (anim_offset_r == 8'hFF || pos_r == LAST) pos_nxt = '0;
            else                                         pos_nxt = pos_r + 6'd1;
          end
        end
        MODE_BREATHE: begin
          emit           = 1'b1;
          shown_mode_nxt = {5'd0, cur_mode_r};
          if (falling_r) lvl = {2'b00, level_r} - {2'b00, breathe_step_r};
          else           lvl = {2'b00, level_r} + {2'b00, breathe_step_r};
          if ($signed(lvl) >= $signed(10'sd255)) begin
            level_nxt   = 8'hFF;
            falling_nxt = 1'b1;
          end else if ($signed(lvl) <= $signed(10'sd0)) begin
            level_nxt   = 8'h00;
            falling_nxt = 1'b0;
          end else begin
            level_nxt   = lvl[7:0];
          end
        end
        default: begin
          emit = redraw_r || (shown_mode_r != {5'd0, cur_mode_r}) ||
                 (shown_colour_r != cur_colour_r);
          if (emit) begin
            shown_mode_nxt   = {5'd0, cur_mode_r};
            shown_colour_nxt = cur_colour_r;
            redraw_nxt       = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rainbow_step_r <= 8'd2;
      chase_iv_r     <= 16'd100;
      spin_iv_r      <= 16'd50;
      breathe_step_r <= 8'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RAINBOW_STEP: rainbow_step_r <= cfg_data[7:0];
        REG_CHASE_IV:     chase_iv_r     <= cfg_data;
        REG_SPINNER_IV:   spin_iv_r      <= cfg_data;
        REG_BREATHE_STEP: breathe_step_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r     <= MODE_OFF;
      cur_colour_r   <= '0;
      shown_mode_r   <= 8'hFF;
      shown_colour_r <= '0;
      anim_offset_r  <= '0;
      pos_r          <= '0;
      level_r        <= '0;
      falling_r      <= 1'b0;
      last_step_r    <= '0;
      redraw_r       <= 1'b1;
    end else if (cmd.decide) begin
      cur_mode_r     <= cur_mode_nxt;
      cur_colour_r   <= cur_colour_nxt;
      shown_mode_r   <= shown_mode_nxt;
      shown_colour_r <= shown_colour_nxt;
      anim_offset_r  <= anim_offset_nxt;
      pos_r          <= pos_nxt;
      level_r        <= level_nxt;
      falling_r      <= falling_nxt;
      last_step_r    <= last_step_nxt;
      redraw_r       <= redraw_nxt;
    end
  end

  logic [7:0] hue;
  logic [23:0] pix_rgb;
  logic        lit;
  logic [6:0]  hr_sum;

  assign hue    = hq_r + hoff_r;
  assign lit    = (cnt_r == pos1_r) || (spin_r && cnt_r == pos2_r);
  assign hr_sum = hr_r + RSTEP;

  always_comb begin
    case (kind_r)
      FK_RAINBOW: pix_rgb = hue_to_rgb(hue);
      FK_DOTS:    pix_rgb = lit ? cur_colour_r : 24'd0;
      default:    pix_rgb = frame_rgb_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
    if (cmd.decide) begin
      kind_r      <= kind_nxt;
      spin_r      <= (cur_mode_r == MODE_SPINNER);
      pos1_r      <= pos_r;
      pos2_r      <= pos2;
      hoff_r      <= anim_offset_r;
      frame_rgb_r <= (cur_mode_r == MODE_SOLID) ? cur_colour_r : 24'd0;
      cnt_r       <= '0;
      hq_r        <= '0;
      hr_r        <= '0;
    end
    if (cmd.calc && cur_mode_r == MODE_BREATHE) begin
      frame_rgb_r <= {scale255(cur_colour_r[23:16], level_r),
                      scale255(cur_colour_r[15:8],  level_r),
                      scale255(cur_colour_r[7:0],   level_r)};
    end
    if (cmd.load) begin
      out_r.pixel_index <= cnt_r;
      out_r.red_out     <= pix_rgb[23:16];
      out_r.green_out   <= pix_rgb[15:8];
      out_r.blue_out    <= pix_rgb[7:0];
      out_r.frame_last  <= (cnt_r == LAST);
      cnt_r             <= cnt_r + 6'd1;
      if (hr_sum >= PIX7) begin
        hr_r <= hr_sum - PIX7;
        hq_r <= hq_r + QSTEP + 8'd1;
      end else begin
        hr_r <= hr_sum;
        hq_r <= hq_r + QSTEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         out_valid_r <= 1'b0;
    else if (cmd.load)  out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_item          = out_r;
  assign status.emit       = emit;
  assign status.frame_done = (cnt_r == LAST);
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

### sv/led_ring_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// led_ring_pattern_generator_top
// LED ring animator: off, solid, rainbow, chase, breathe and spinner frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item): a set-mode item stores mode and
// colour and yields nothing; an update item carries the time in ms and may
// yield one frame of PIXELS pixel items, pixel 0 first, frame_last on the end.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 rainbow step, 1 chase interval, 2 spinner interval, 3 breathe step,
// other indexes ignored. Write only while idle.
// Result channel (out_valid/out_ready/out_item): one output register.
// Sequence: an item without results passes the accept and decide states; an
// update with a frame then passes calc and emit states, and emit loads one
// pixel per cycle into the output register while the receiver takes them.
// The rate is set by the single pixel generator behind the output register.
// The next item is accepted while the last pixel still waits to be taken.
// A stalled receiver holds the pixel sequencer; nothing is dropped.
// Reset (rst_n, synchronous): registers to defaults, mode off, redraw pending.
// ----------------------------------------------------------------------------
module led_ring_pattern_generator_top #(
  parameter int PIXELS = lrpg_pkg::PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lrpg_pkg::in_item_t              in_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrpg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lrpg_pkg::out_item_t             out_item
);
  import lrpg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lrpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lrpg_datapath #(
    .PIXELS (PIXELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### sim/lrpg_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrpg_frame_checker
// Watches the item, config and pixel channels of the LED ring pattern
// generator. It keeps its own copy of the animation state, predicts the frame
// that each accepted update should produce and compares every accepted pixel,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module lrpg_frame_checker #(
  parameter int PIXELS = lrpg_pkg::PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  lrpg_pkg::in_item_t              in_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lrpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrpg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  lrpg_pkg::out_item_t             out_item,
  output int                              fail_count,
  output int                              outstanding
);

  import lrpg_pkg::*;

  logic [7:0]  rainbow_step;
  logic [15:0] chase_iv;
  logic [15:0] spin_iv;
  logic [7:0]  breathe_step;

  logic [2:0]  cur_mode;
  logic [23:0] cur_colour;
  logic [7:0]  shown_mode;
  logic [23:0] shown_colour;
  logic [7:0]  anim_offset;
  logic [7:0]  breathe_level;
  logic        breathe_falling;
  logic [31:0] last_step_time;
  logic        redraw_pending;

  out_item_t   expected_pixels[$];

  initial begin
    fail_count  = 0;
    outstanding <= 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: pixel check: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_frame(input in_item_t it);
    logic [23:0] colour;
    logic [23:0] flat;
    logic [23:0] px;
    logic [31:0] elapsed;
    logic [15:0] interval;
    logic [7:0]  hue;
    out_item_t   pix;
    bit          emit;
    int          lvl;
    int          pos1;
    int          pos2;
    int          region;
    int          rem;
    int          q;
    int          t;
    colour = {it.red, it.green, it.blue};
    if (it.command == CMD_SET) begin
      if (it.mode != cur_mode || colour != cur_colour) begin
        redraw_pending = 1'b1;
        if (it.mode != cur_mode) begin
          anim_offset     = 8'd0;
          breathe_level   = 8'd0;
          breathe_falling = 1'b0;
        end
      end
      cur_mode   = it.mode;
      cur_colour = colour;
      return;
    end

    flat = 24'd0;
    emit = 1'b1;
    pos1 = anim_offset % PIXELS;
    pos2 = (pos1 + PIXELS / 2) % PIXELS;
    case (cur_mode)
      MODE_RAINBOW: emit = 1'b1;
      MODE_CHASE, MODE_SPINNER: begin
        interval = (cur_mode == MODE_CHASE) ? chase_iv : spin_iv;
        elapsed  = it.now_ms - last_step_time;
        emit     = elapsed >= {16'd0, interval};
      end
      MODE_BREATHE: begin
        if (breathe_falling) lvl = int'(breathe_level) - int'(breathe_step);
        else lvl = int'(breathe_level) + int'(breathe_step);
        if (lvl >= 255) begin
          lvl = 255;
          breathe_falling = 1'b1;
        end else if (lvl <= 0) begin
          lvl = 0;
          breathe_falling = 1'b0;
        end
        breathe_level = 8'(lvl);
        flat = {8'((int'(cur_colour[23:16]) * lvl) / 255),
                8'((int'(cur_colour[15:8]) * lvl) / 255),
                8'((int'(cur_colour[7:0]) * lvl) / 255)};
      end
      default: begin
        emit = redraw_pending || ({5'd0, cur_mode} != shown_mode) ||
               (cur_colour != shown_colour);
        flat = (cur_mode == MODE_SOLID) ? cur_colour : 24'd0;
      end
    endcase

    if (emit) begin
      for (int i = 0; i < PIXELS; i++) begin
        px = flat;
        if (cur_mode == MODE_RAINBOW) begin
          hue    = 8'((i * 256) / PIXELS + int'(anim_offset));
          region = int'(hue) / 43;
          rem    = ((int'(hue) - region * 43) * 6) & 8'hFF;
          q      = (255 * (255 - ((255 * rem) >> 8))) >> 8;
          t      = (255 * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
          case (region)
            0:       px = {8'd255, 8'(t), 8'd0};
            1:       px = {8'(q), 8'd255, 8'd0};
            2:       px = {8'd0, 8'd255, 8'(t)};
            3:       px = {8'd0, 8'(q), 8'd255};
            4:       px = {8'(t), 8'd0, 8'd255};
            default: px = {8'd255, 8'd0, 8'(q)};
          endcase
        end else if (cur_mode == MODE_CHASE || cur_mode == MODE_SPINNER) begin
          px = (i == pos1 || (cur_mode == MODE_SPINNER && i == pos2)) ? cur_colour : 24'd0;
        end
        pix.pixel_index = 6'(i);
        pix.red_out     = px[23:16];
        pix.green_out   = px[15:8];
        pix.blue_out    = px[7:0];
        pix.frame_last  = (i == PIXELS - 1);
        expected_pixels.push_back(pix);
      end
    end

    case (cur_mode)
      MODE_RAINBOW: begin
        anim_offset = anim_offset + rainbow_step;
        shown_mode  = {5'd0, cur_mode};
      end
      MODE_CHASE, MODE_SPINNER: begin
        if (emit) begin
          anim_offset    = anim_offset + 8'd1;
          last_step_time = it.now_ms;
        end
        shown_mode = {5'd0, cur_mode};
      end
      MODE_BREATHE: shown_mode = {5'd0, cur_mode};
      default: begin
        if (emit) begin
          shown_mode     = {5'd0, cur_mode};
          shown_colour   = cur_colour;
          redraw_pending = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rainbow_step    = 8'd2;
      chase_iv        = 16'd100;
      spin_iv         = 16'd50;
      breathe_step    = 8'd5;
      cur_mode        = MODE_OFF;
      cur_colour      = 24'd0;
      shown_mode      = 8'd255;
      shown_colour    = 24'd0;
      anim_offset     = 8'd0;
      breathe_level   = 8'd0;
      breathe_falling = 1'b0;
      last_step_time  = 32'd0;
      redraw_pending  = 1'b1;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAINBOW_STEP: rainbow_step = cfg_data[7:0];
          REG_CHASE_IV:     chase_iv     = cfg_data;
          REG_SPINNER_IV:   spin_iv      = cfg_data;
          REG_BREATHE_STEP: breathe_step = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_item), 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_item.pixel_index != want.pixel_index)
            report_mismatch("pixel_index", 32'(out_item.pixel_index), 32'(want.pixel_index));
          if (out_item.red_out != want.red_out)
            report_mismatch("red_out", 32'(out_item.red_out), 32'(want.red_out));
          if (out_item.green_out != want.green_out)
            report_mismatch("green_out", 32'(out_item.green_out), 32'(want.green_out));
          if (out_item.blue_out != want.blue_out)
            report_mismatch("blue_out", 32'(out_item.blue_out), 32'(want.blue_out));
          if (out_item.frame_last != want.frame_last)
            report_mismatch("frame_last", 32'(out_item.frame_last), 32'(want.frame_last));
        end
      end
      if (in_valid && in_ready) predict_frame(in_item);
    end
    outstanding <= expected_pixels.size();
  end

endmodule

### sim/led_ring_pattern_generator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_ring_pattern_generator_top_tb
// Drives set-mode and update items, register writes and a random stalling
// receiver into the LED ring pattern generator. A directed opening covers each
// mode, redraw rules, interval timing across the time wrap and the spare mode
// codes; random phases follow under several register settings, the extremes
// among them. Checking is done by the frame checker beside the block.
// ----------------------------------------------------------------------------
module led_ring_pattern_generator_top_tb;

  import lrpg_pkg::*;

  localparam int PIXELS      = PIXELS_DEF;
  localparam int SETTLE      = PIXELS + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int IN_ITEM_W   = $bits(in_item_t);

  localparam logic [2:0]           MODE_SPARE_6     = 3'd6;
  localparam logic [2:0]           MODE_SPARE_7     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = {CFG_IDX_W{1'b1}};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;

  int          fail_count;
  int          outstanding;
  int          quiet_cycles;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_out_req;
  logic [31:0] clock_ms;
  logic [15:0] chase_iv_t;
  logic [15:0] spin_iv_t;
  logic [2:0]  last_mode;
  logic [23:0] last_colour;

  led_ring_pattern_generator_top #(.PIXELS(PIXELS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  lrpg_frame_checker #(.PIXELS(PIXELS)) u_frame_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out_req = 1'b0;
      end else begin
        out_ready <= !(rx_idle && $urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic offer(input in_item_t it);
    if (tx_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_set(input logic [2:0] mode, input logic [23:0] colour);
    in_item_t it;
    it         = IN_ITEM_W'({$urandom, $urandom});
    it.command = CMD_SET;
    it.mode    = mode;
    {it.red, it.green, it.blue} = colour;
    last_mode   = mode;
    last_colour = colour;
    offer(it);
  endtask

  task automatic send_update(input logic [31:0] now);
    in_item_t it;
    it         = IN_ITEM_W'({$urandom, $urandom});
    it.command = CMD_UPDATE;
    it.now_ms  = now;
    offer(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] rstep, input logic [15:0] chase,
                                input logic [15:0] spin, input logic [7:0] bstep);
    drain();
    cfg_write(REG_RAINBOW_STEP, {8'($urandom), rstep});
    cfg_write(REG_CHASE_IV, chase);
    cfg_write(REG_SPINNER_IV, spin);
    cfg_write(REG_BREATHE_STEP, {8'($urandom), bstep});
    // writes to indexes past the register list must be ignored
    cfg_write(4'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), 16'($urandom));
    cfg_valid  <= 1'b0;
    chase_iv_t = chase;
    spin_iv_t  = spin;
  endtask

  task automatic run_random(input int count);
    int          n;
    int          kind;
    int          burst;
    logic [2:0]  mode;
    logic [23:0] colour;
    logic [15:0] iv;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        if ($urandom_range(9) == 0)
          mode = 3'($urandom_range(MODE_SPARE_6, MODE_SPARE_7));
        else
          mode = 3'($urandom_range(MODE_OFF, MODE_SPINNER));
        colour = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom);
        send_set(mode, colour);
        n++;
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          iv = (mode == MODE_CHASE) ? chase_iv_t : spin_iv_t;
          if (mode == MODE_CHASE || mode == MODE_SPINNER)
            clock_ms = clock_ms + $urandom_range(0, 2 * int'(iv) + 2);
          else
            clock_ms = clock_ms + $urandom_range(0, 200);
          send_update(clock_ms);
          n++;
        end
      end else if (kind < 86) begin
        send_set(last_mode, ($urandom_range(1) == 0) ? last_colour : 24'($urandom));
        n++;
      end else if (kind < 93) begin
        send_set(3'($urandom), 24'($urandom));
        n++;
      end else begin
        clock_ms = $urandom;
        send_update(clock_ms);
        n++;
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_item      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_out_req = 1'b0;
    clock_ms     = 32'd0;
    chase_iv_t   = 16'd100;
    spin_iv_t    = 16'd50;
    last_mode    = MODE_OFF;
    last_colour  = 24'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // redraw after reset, then nothing while unchanged
    send_update(32'd5);
    send_update(32'd6);
    send_set(MODE_SOLID, 24'hFFFFFF);
    send_update(32'd7);
    send_set(MODE_SOLID, 24'hFFFFFF);
    send_update(32'd8);
    send_set(MODE_SOLID, 24'h000000);
    send_update(32'd9);
    send_set(MODE_RAINBOW, 24'h123456);
    send_update(32'd10);
    send_update(32'd11);
    // chase timing, including the wrap of the millisecond time
    send_set(MODE_CHASE, 24'h00FF00);
    send_update(32'd50);
    send_update(32'd100);
    send_update(32'hFFFF_FFF0);
    send_update(32'h0000_0050);
    send_update(32'h0000_0054);
    send_set(MODE_SPINNER, 24'h0000FF);
    send_update(32'h0000_0086);
    send_set(MODE_BREATHE, 24'hFF8001);
    send_update(32'd200);
    send_update(32'd201);
    send_set(MODE_SPARE_6, 24'h00FFFF);
    send_update(32'd202);
    send_set(MODE_SPARE_7, 24'hABCDEF);
    send_update(32'd203);

    clock_ms = 32'hFFFF_0000;
    write_settings(8'd255, 16'd0, 16'd65535, 8'd128);
    run_random(60);
    write_settings(8'd0, 16'd65535, 16'd0, 8'd1);
    run_random(60);
    // breathe step of zero
    write_settings(8'd2, 16'd100, 16'd50, 8'd0);
    run_random(40);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_settings(8'($urandom), 16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                   8'($urandom_range(1, 128)));
    run_random(80);
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // long receiver hold-off while rainbow frames keep coming
    send_set(MODE_RAINBOW, 24'($urandom));
    hold_out_req = 1'b1;
    repeat (10) begin
      clock_ms = clock_ms + 32'd1;
      send_update(clock_ms);
    end
    drain();

    repeat (3) begin
      write_settings(8'($urandom), 16'($urandom), 16'($urandom_range(0, 500)),
                     8'($urandom_range(1, 128)));
      run_random(50);
    end

    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
sv/lrpg_pkg.sv
sv/lrpg_ctrl.sv
sv/lrpg_datapath.sv
sv/led_ring_pattern_generator_top.sv
sim/lrpg_frame_checker.sv
sim/led_ring_pattern_generator_top_tb.sv
